// File: rtl/rffc_pkg.sv
`default_nettype none
package rffc_pkg;

  localparam int unsigned DATA_W = 32;  // Q16.16 samples, gains
  localparam int unsigned TIME_W = 25;  // dt and RC, 2^-24 s units
  localparam int unsigned DEN_W  = 26;  // RC + dt
  localparam int unsigned LIM_W  = 31;
  localparam int unsigned IDX_W  = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_RC    = 3'd0,
    REG_GPOS  = 3'd1,
    REG_GRATE = 3'd2,
    REG_GACC  = 3'd3,
    REG_LIMIT = 3'd4
  } rffc_reg_e;

  // control into the serial multiplier
  typedef struct packed {
    logic start;     // load operands, begin shifting
    logic clear;     // zero accumulator on start
    logic b_signed;  // top multiplier bit weighs negative
  } rffc_mul_ctl_t;

endpackage
`default_nettype wire

// File: rtl/reference_feedforward_controller.sv
`default_nettype none
// Channel  Dir  Handshake                 Payload
// in       in   in_valid_i / in_ready_o   reference_sample_i, elapsed_time_i
// out      out  out_valid_o / out_ready_i drive_value_o, filtered_reference_o,
//                                         reference_rate_o, reference_accel_o
// cfg      in   cfg_we_i (no wait)        cfg_idx_i, cfg_data_i
//
// One item at a time: each item takes five passes of the bit-serial shift-add
// multiplier and three passes of the restoring divider.
// A new item is taken while the previous result waits in the output register;
// a finished item waits in S_OUT only while that register is still full.
// Reset clears config registers and the filter / derivative history.
module reference_feedforward_controller #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic signed [rffc_pkg::DATA_W-1:0] reference_sample_i,
  input  wire logic        [rffc_pkg::TIME_W-1:0] elapsed_time_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic signed [rffc_pkg::DATA_W-1:0]      drive_value_o,
  output logic signed [rffc_pkg::DATA_W-1:0]      filtered_reference_o,
  output logic signed [rffc_pkg::DATA_W-1:0]      reference_rate_o,
  output logic signed [rffc_pkg::DATA_W-1:0]      reference_accel_o,
  input  wire logic                               cfg_we_i,
  input  wire logic        [rffc_pkg::IDX_W-1:0]  cfg_idx_i,
  input  wire logic        [rffc_pkg::DATA_W-1:0] cfg_data_i
);
  import rffc_pkg::*;

  localparam int unsigned VW  = VALUE_WIDTH;
  localparam int unsigned MBW = (VW > 32) ? VW : 32;       // multiplier bits
  localparam int unsigned AW  = MBW + 34;                  // accumulator
  localparam int unsigned NW  = (VW + 26 > 58) ? VW + 26 : 58;  // dividend mag
  localparam int unsigned RW  = AW - 16;                   // rounded drive
  localparam logic signed [NW:0] SatMax = (NW+1)'((64'sd1 <<< (VW - 1)) - 64'sd1);
  localparam logic signed [NW:0] SatMin = -SatMax - (NW+1)'(1);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_MREF  = 11'b00000000010,
    S_MFLT  = 11'b00000000100,
    S_DFLT  = 11'b00000001000,
    S_DRATE = 11'b00000010000,
    S_DACC  = 11'b00000100000,
    S_MP0   = 11'b00001000000,
    S_MP1   = 11'b00010000000,
    S_MP2   = 11'b00100000000,
    S_ROUND = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_e;

  // config
  logic        [TIME_W-1:0] rc_q;
  logic signed [DATA_W-1:0] gpos_q, grate_q, gacc_q;
  logic        [LIM_W-1:0]  limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q    <= '0;
      gpos_q  <= '0;
      grate_q <= '0;
      gacc_q  <= '0;
      limit_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RC:    rc_q    <= cfg_data_i[TIME_W-1:0];
        REG_GPOS:  gpos_q  <= cfg_data_i;
        REG_GRATE: grate_q <= cfg_data_i;
        REG_GACC:  gacc_q  <= cfg_data_i;
        REG_LIMIT: limit_q <= cfg_data_i[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  state_e                   state_q;
  logic                     go_q;     // unit started in this state
  logic                     ovalid_q;
  logic signed [DATA_W-1:0] ref_q;
  logic        [TIME_W-1:0] dt_q;
  logic signed [DATA_W-1:0] f_q, pf_q;    // filter state, previous filtered
  logic signed [VW-1:0]     pr_q;         // previous rate
  logic signed [VW-1:0]     rate_q, accel_q;
  logic signed [RW-1:0]     drv_q;
  logic signed [DATA_W-1:0] o_drv_q, o_f_q, o_rate_q, o_acc_q;

  rffc_mul_ctl_t        mctl;
  logic signed [DATA_W-1:0] ma;
  logic [MBW-1:0]       mb;
  logic                 mbusy;
  logic signed [AW-1:0] macc;
  logic                 dstart;
  logic signed [NW:0]   dnum;
  logic [DEN_W-1:0]     dden;
  logic                 dbusy;
  logic signed [NW:0]   dquo;
  logic signed [VW-1:0] dsat;
  logic                 mul_st, div_st, fin, out_free;
  logic signed [RW-1:0] lim_s, drv_c;

  assign mul_st   = (state_q == S_MREF) || (state_q == S_MFLT) || (state_q == S_MP0) ||
                    (state_q == S_MP1) || (state_q == S_MP2);
  assign div_st   = (state_q == S_DFLT) || (state_q == S_DRATE) || (state_q == S_DACC);
  assign fin      = go_q && !(mul_st ? mbusy : dbusy);
  assign out_free = !ovalid_q || out_ready_i;

  // operand select for the shared units
  always_comb begin
    mctl.start    = mul_st && !go_q;
    mctl.clear    = 1'b1;
    mctl.b_signed = 1'b1;
    ma            = gpos_q;
    mb            = MBW'(f_q);
    case (state_q)
      S_MREF: begin
        mctl.b_signed = 1'b0;
        ma            = ref_q;
        mb            = MBW'(dt_q);
      end
      S_MFLT: begin
        mctl.clear    = 1'b0;
        mctl.b_signed = 1'b0;
        ma            = f_q;
        mb            = MBW'(rc_q);
      end
      S_MP1: begin
        mctl.clear = 1'b0;
        ma         = grate_q;
        mb         = MBW'(rate_q);
      end
      S_MP2: begin
        mctl.clear = 1'b0;
        ma         = gacc_q;
        mb         = MBW'(accel_q);
      end
      default: ;
    endcase
  end

  always_comb begin
    dstart = div_st && !go_q;
    dden   = DEN_W'(dt_q);
    case (state_q)
      S_DFLT: begin
        dnum = macc[NW:0];
        dden = DEN_W'(rc_q) + DEN_W'(dt_q);
      end
      S_DRATE: dnum = ((NW+1)'(f_q) - (NW+1)'(pf_q)) <<< 24;
      default: dnum = ((NW+1)'(rate_q) - (NW+1)'(pr_q)) <<< 24;
    endcase
  end

  // saturate quotient to VALUE_WIDTH
  always_comb begin
    if (dquo > SatMax) begin
      dsat = SatMax[VW-1:0];
    end else if (dquo < SatMin) begin
      dsat = SatMin[VW-1:0];
    end else begin
      dsat = dquo[VW-1:0];
    end
  end

  assign lim_s = signed'(RW'(limit_q));
  always_comb begin
    if (drv_q > lim_s) begin
      drv_c = lim_s;
    end else if (drv_q < -lim_s) begin
      drv_c = -lim_s;
    end else begin
      drv_c = drv_q;
    end
  end

  rffc_serial_mul #(.BW(MBW), .AW(AW)) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mctl),
    .a_i    (ma),
    .b_i    (mb),
    .busy_o (mbusy),
    .acc_o  (macc)
  );

  rffc_serial_div #(.NW(NW), .DW(DEN_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dstart),
    .num_i   (dnum),
    .den_i   (dden),
    .busy_o  (dbusy),
    .quo_o   (dquo)
  );

  // sequencer and history state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      go_q     <= 1'b0;
      ovalid_q <= 1'b0;
      f_q      <= '0;
      pf_q     <= '0;
      pr_q     <= '0;
    end else begin
      if (state_q == S_OUT && out_free) begin
        ovalid_q <= 1'b1;
      end else if (ovalid_q && out_ready_i) begin
        ovalid_q <= 1'b0;
      end
      if (mctl.start || dstart) begin
        go_q <= 1'b1;
      end else if (fin) begin
        go_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE:  if (in_valid_i) state_q <= S_MREF;
        S_MREF:  if (fin) state_q <= S_MFLT;
        S_MFLT:  if (fin) state_q <= S_DFLT;
        S_DFLT: if (fin) begin
          f_q     <= dquo[DATA_W-1:0];   // weighted mean, always in range
          state_q <= S_DRATE;
        end
        S_DRATE: if (fin) state_q <= S_DACC;
        S_DACC:  if (fin) state_q <= S_MP0;
        S_MP0:   if (fin) state_q <= S_MP1;
        S_MP1:   if (fin) state_q <= S_MP2;
        S_MP2:   if (fin) state_q <= S_ROUND;
        S_ROUND: state_q <= S_OUT;
        S_OUT: if (out_free) begin
          pf_q     <= f_q;
          pr_q     <= rate_q;
          state_q  <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      ref_q <= reference_sample_i;
      dt_q  <= (elapsed_time_i == '0) ? TIME_W'(1) : elapsed_time_i;
    end
    if (state_q == S_DRATE && fin) rate_q  <= dsat;
    if (state_q == S_DACC && fin)  accel_q <= dsat;
    // round half up: floor((sum + 2^15) / 2^16)
    if (state_q == S_ROUND) drv_q <= RW'((macc + AW'(32768)) >>> 16);
    if (state_q == S_OUT && out_free) begin
      o_drv_q  <= drv_c[DATA_W-1:0];
      o_f_q    <= f_q;
      o_rate_q <= DATA_W'(rate_q);
      o_acc_q  <= DATA_W'(accel_q);
    end
  end

  assign in_ready_o           = (state_q == S_IDLE);
  assign out_valid_o          = ovalid_q;
  assign drive_value_o        = o_drv_q;
  assign filtered_reference_o = o_f_q;
  assign reference_rate_o     = o_rate_q;
  assign reference_accel_o    = o_acc_q;

endmodule
`default_nettype wire

// File: rtl/rffc_serial_mul.sv
`default_nettype none
module rffc_serial_mul #(
  parameter int unsigned BW = 32,
  parameter int unsigned AW = 66
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire rffc_pkg::rffc_mul_ctl_t            ctl_i,
  input  wire logic signed [rffc_pkg::DATA_W-1:0] a_i,
  input  wire logic        [BW-1:0]               b_i,
  output logic                                    busy_o,
  output logic signed [AW-1:0]                    acc_o
);
  import rffc_pkg::*;

  localparam int unsigned CW = $clog2(BW);

  logic                 busy_q;
  logic [CW-1:0]        cnt_q;
  logic signed [AW-1:0] a_q;
  logic [BW-1:0]        b_q;
  logic                 sgn_q;
  logic signed [AW-1:0] acc_q;
  logic                 last;

  assign last = (cnt_q == CW'(BW - 1));

  // radix-2 shift-add; last bit of a signed multiplier subtracts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (ctl_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (last) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      a_q   <= AW'(a_i);
      b_q   <= b_i;
      sgn_q <= ctl_i.b_signed;
      if (ctl_i.clear) begin
        acc_q <= '0;
      end
    end else if (busy_q) begin
      if (b_q[0]) begin
        if (last && sgn_q) begin
          acc_q <= acc_q - a_q;
        end else begin
          acc_q <= acc_q + a_q;
        end
      end
      a_q <= a_q <<< 1;
      b_q <= b_q >> 1;
    end
  end

  assign busy_o = busy_q;
  assign acc_o  = acc_q;

endmodule
`default_nettype wire

// File: rtl/rffc_serial_div.sv
`default_nettype none
module rffc_serial_div #(
  parameter int unsigned NW = 58,
  parameter int unsigned DW = 26
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic signed [NW:0]   num_i,
  input  wire logic        [DW-1:0] den_i,
  output logic                      busy_o,
  output logic signed [NW:0]        quo_o
);
  import rffc_pkg::*;

  localparam int unsigned CW = $clog2(NW);

  typedef enum logic [4:0] {
    DV_IDLE = 5'b00001,
    DV_ABS  = 5'b00010,
    DV_HALF = 5'b00100,
    DV_ITER = 5'b01000,
    DV_SIGN = 5'b10000
  } dv_state_e;

  dv_state_e         state_q;
  logic [CW-1:0]     cnt_q;
  logic signed [NW:0] sig_q;
  logic [DW-1:0]     den_q;
  logic [DW:0]       rem_q;
  logic              neg_q;
  logic [DW:0]       trial;
  logic              ge;

  assign trial = {rem_q[DW-1:0], sig_q[NW-1]};
  assign ge    = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        DV_IDLE: if (start_i) state_q <= DV_ABS;
        DV_ABS:  state_q <= DV_HALF;
        DV_HALF: begin
          state_q <= DV_ITER;
          cnt_q   <= '0;
        end
        DV_ITER: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CW'(NW - 1)) state_q <= DV_SIGN;
        end
        DV_SIGN: state_q <= DV_IDLE;
        default: state_q <= DV_IDLE;
      endcase
    end
  end

  // |num| + den/2, restoring divide one bit a cycle, then sign back on
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      DV_IDLE: if (start_i) begin
        sig_q <= num_i;
        den_q <= den_i;
        neg_q <= num_i[NW];
      end
      DV_ABS:  if (neg_q) sig_q <= -sig_q;
      DV_HALF: begin
        sig_q <= sig_q + (NW+1)'(den_q >> 1);
        rem_q <= '0;
      end
      DV_ITER: begin
        rem_q <= ge ? (trial - {1'b0, den_q}) : trial;
        sig_q <= {1'b0, sig_q[NW-2:0], ge};
      end
      DV_SIGN: if (neg_q) sig_q <= -sig_q;
      default: ;
    endcase
  end

  assign busy_o = (state_q != DV_IDLE);
  assign quo_o  = sig_q;

endmodule
`default_nettype wire
